// File: rtl/bmhpq_pkg.sv
// Shared types and codes for the binary max-heap priority queue.
package bmhpq_pkg;

    // Field widths of the request and result items.
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0]            op_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [INDEX_W-1:0]         index_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;

    // Request operations.
    localparam op_t OP_INSERT  = 2'd0;
    localparam op_t OP_EXTRACT = 2'd1;
    localparam op_t OP_CHANGE  = 2'd2;
    localparam op_t OP_REMOVE  = 2'd3;

    // Result status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_INDEX = 2'd3;

endpackage

// File: rtl/binary_max_heap_priority_queue.sv
// Binary max-heap priority queue: one store port pair, one signed comparator, a small sequencer.
// One request is in work at a time, so a new request is not taken before the last result has
// been loaded into the output register; an entry moves at most log2(CAPACITY) levels.
// Reset clears the entry count and the control state; store contents stay undefined until written.
module binary_max_heap_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bmhpq_pkg::op_t       operation,
    input  bmhpq_pkg::value_t    priority_value,
    input  bmhpq_pkg::index_t    heap_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bmhpq_pkg::status_t   status,
    output bmhpq_pkg::value_t    taken_value,
    output bmhpq_pkg::value_t    max_value,
    output logic                 max_valid,
    output bmhpq_pkg::count_t    entry_count
);
    import bmhpq_pkg::*;

    // Address, count and child-index widths follow from the capacity.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LD_A   = 4'd1;
    localparam logic [3:0] S_LD_B   = 4'd2;
    localparam logic [3:0] S_LD_C   = 4'd3;
    localparam logic [3:0] S_UP_RD  = 4'd4;
    localparam logic [3:0] S_UP_CMP = 4'd5;
    localparam logic [3:0] S_DN_L   = 4'd6;
    localparam logic [3:0] S_DN_R   = 4'd7;
    localparam logic [3:0] S_DN_CMP = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_RES    = 4'd10;

    logic [3:0]     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]  pos_reg, pos_next;
    op_t            op_reg, op_next;
    value_t         val_reg, val_next;
    value_t         v_reg, v_next;
    value_t         old_reg, old_next;
    value_t         taken_reg, taken_next;
    status_t        st_reg, st_next;
    value_t         best_val_reg, best_val_next;
    logic [AW-1:0]  best_idx_reg, best_idx_next;
    logic           right_ok_reg, right_ok_next;

    logic           out_valid_reg, out_valid_next;
    status_t        status_reg;
    value_t         taken_value_reg;
    value_t         max_value_reg;
    logic           max_valid_reg;
    count_t         entry_count_reg;
    logic           out_load;

    // Heap store with one write port and one registered read port.
    value_t         heap_mem [CAPACITY];
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    value_t         mem_wd;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    value_t         rd_data_reg;

    logic [AW-1:0]  parent_idx;
    logic [AW-1:0]  last_idx;
    logic [XW-1:0]  l_idx;
    logic [XW-1:0]  r_idx;
    logic           take_right;
    value_t         sel_val;
    logic [AW-1:0]  sel_idx;

    value_t         cmp_a;
    value_t         cmp_b;
    logic           cmp_gt;

    assign in_ready = (state_reg == S_IDLE);

    // Neighbour positions of the current entry.
    assign parent_idx = AW'((pos_reg - 1'b1) >> 1);
    assign last_idx   = AW'(cnt_reg - 1'b1);
    assign l_idx      = XW'({pos_reg, 1'b1});
    assign r_idx      = l_idx + 1'b1;

    // Shared signed comparator; its operands follow the sequencer state.
    always_comb
    begin
        cmp_a = rd_data_reg;
        cmp_b = v_reg;
        unique case (state_reg)
            S_LD_C:
            begin
                cmp_a = (op_reg == OP_CHANGE) ? val_reg : rd_data_reg;
                cmp_b = old_reg;
            end
            S_UP_CMP:
            begin
                cmp_a = v_reg;
                cmp_b = rd_data_reg;
            end
            S_DN_CMP:
            begin
                cmp_a = rd_data_reg;
                cmp_b = best_val_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign cmp_gt = (cmp_a > cmp_b);

    // Final child choice of a sift-down step: the right child wins only if strictly greater.
    assign take_right = right_ok_reg && cmp_gt;
    assign sel_val    = take_right ? rd_data_reg : best_val_reg;
    assign sel_idx    = take_right ? AW'(r_idx) : best_idx_reg;

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        v_next        = v_reg;
        old_next      = old_reg;
        taken_next    = taken_reg;
        st_next       = st_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        right_ok_next = right_ok_reg;
        mem_we        = 1'b0;
        mem_wa        = pos_reg;
        mem_wd        = v_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    val_next   = priority_value;
                    taken_next = '0;
                    st_next    = ST_OK;
                    case (operation)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                pos_next   = AW'(cnt_reg);
                                cnt_next   = cnt_reg + 1'b1;
                                v_next     = priority_value;
                                state_next = S_UP_RD;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                pos_next   = '0;
                                state_next = S_LD_A;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FIN;
                            end
                            else if (!(IW'(heap_index) < IW'(cnt_reg)))
                            begin
                                st_next    = ST_INDEX;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                pos_next   = AW'(heap_index);
                                state_next = S_LD_A;
                            end
                        end
                    endcase
                end
            end
            S_LD_A:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = S_LD_B;
            end
            S_LD_B:
            begin
                old_next   = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = last_idx;
                state_next = S_LD_C;
            end
            S_LD_C:
            begin
                // Read data now holds the last entry.
                case (op_reg)
                    OP_EXTRACT:
                    begin
                        taken_next = old_reg;
                        cnt_next   = cnt_reg - 1'b1;
                        v_next     = rd_data_reg;
                        pos_next   = '0;
                        state_next = S_DN_L;
                    end
                    OP_CHANGE:
                    begin
                        v_next     = val_reg;
                        state_next = cmp_gt ? S_UP_RD : S_DN_L;
                    end
                    default:
                    begin
                        taken_next = old_reg;
                        cnt_next   = cnt_reg - 1'b1;
                        if (pos_reg == last_idx)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            v_next     = rd_data_reg;
                            state_next = cmp_gt ? S_UP_RD : S_DN_L;
                        end
                    end
                endcase
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    // Parent moves down into the hole; carry on one level up.
                    mem_wd     = rd_data_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_L:
            begin
                if (l_idx < XW'(cnt_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(l_idx);
                    state_next = S_DN_R;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN_R:
            begin
                if (cmp_gt)
                begin
                    best_val_next = rd_data_reg;
                    best_idx_next = AW'(l_idx);
                end
                else
                begin
                    best_val_next = v_reg;
                    best_idx_next = pos_reg;
                end
                right_ok_next = (r_idx < XW'(cnt_reg));
                rd_en         = (r_idx < XW'(cnt_reg));
                rd_addr       = AW'(r_idx);
                state_next    = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (sel_idx == pos_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    // Larger child moves up into the hole; carry on one level down.
                    mem_wd     = sel_val;
                    pos_next   = sel_idx;
                    state_next = S_DN_L;
                end
            end
            S_FIN:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        op_reg       <= op_next;
        val_reg      <= val_next;
        v_reg        <= v_next;
        old_reg      <= old_next;
        taken_reg    <= taken_next;
        st_reg       <= st_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        right_ok_reg <= right_ok_next;
        if (out_load)
        begin
            status_reg      <= st_reg;
            taken_value_reg <= taken_reg;
            max_value_reg   <= (cnt_reg != '0) ? rd_data_reg : '0;
            max_valid_reg   <= (cnt_reg != '0);
            entry_count_reg <= COUNT_W'(cnt_reg);
        end
    end

    // Heap store.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign taken_value = taken_value_reg;
    assign max_value   = max_value_reg;
    assign max_valid   = max_valid_reg;
    assign entry_count = entry_count_reg;

    // The entry count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // An accepted request always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("request accepted without starting work");

    // A result is only loaded while the output register is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule
